// ===== hw/rtl/cf2ci_pkg.sv =====
// ============================================================================
// cf2ci_pkg: shared types and constants for complex float to cint32
// Payload structs, register indexes and conversion constants.
// ============================================================================
`default_nettype none
package cf2ci_pkg;

    localparam int unsigned FracW = 5;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] RegFractionBits = 8'd0;
    localparam logic [CfgIdxW-1:0] RegSafeMode = 8'd1;

    localparam logic [31:0] FixMax = 32'h7FFF_FFFF;
    localparam logic [31:0] FixMin = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] imag_bits;
        logic [31:0] real_bits;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] imag_fixed;
        logic signed [31:0] real_fixed;
    } out_item_t;

    typedef struct packed {
        logic [FracW-1:0] fraction_bits;
        logic             safe_mode;
    } cfg_t;

    // per-lane result after stage 1, before sign is applied
    typedef struct packed {
        logic        zero;
        logic        sat;
        logic        sign;
        logic [31:0] mag;
    } lane_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cf2ci_lane.sv =====
// ============================================================================
// cf2ci_lane: one float32 to fixed-point conversion lane
// Decodes one part, shifts the mantissa by the scale and rounds or truncates.
// ============================================================================
`default_nettype none
module cf2ci_lane
(
    input  wire logic [31:0]        bits,
    input  wire cf2ci_pkg::cfg_t    cfg,
    output cf2ci_pkg::lane_res_t    res
);
    logic       sign;
    logic [7:0] expo;
    logic [23:0] mant;
    logic signed [9:0] e2;
    logic [4:0] k;
    logic [55:0] shl;
    logic [23:0] shr;
    logic        rbit;
    logic [24:0] rmag;

    always_comb
    begin
        sign = bits[31];
        expo = bits[30:23];
        mant = {(expo != 8'd0), bits[22:0]};
        e2 = $signed({2'b00, (expo == 8'd0) ? 8'd1 : expo}) - 10'sd150
            + $signed({5'b0, cfg.fraction_bits});
        k = 5'd0;
        shl = '0;
        shr = '0;
        rbit = 1'b0;
        rmag = '0;
        res.sign = sign;
        res.zero = 1'b0;
        res.sat = 1'b0;
        res.mag = '0;
        if (expo == 8'hFF)
        begin
            res.zero = (bits[22:0] != 23'd0);
            res.sat = !res.zero;
        end
        else if (mant == 24'd0)
        begin
            res.zero = 1'b1;
        end
        else if (e2 >= 10'sd0)
        begin
            if (e2 > 10'sd31)
            begin
                res.sat = 1'b1;
            end
            else
            begin
                shl = {32'd0, mant} << e2[4:0];
                res.sat = (shl[55:31] != 25'd0);
                res.mag = shl[31:0];
            end
        end
        else if (e2 > -10'sd26)
        begin
            k = 5'(-e2);
            shr = mant >> k;
            rbit = cfg.safe_mode && mant[k - 5'd1];
            rmag = {1'b0, shr} + {24'd0, rbit};
            res.mag = {7'd0, rmag};
        end
        else
        begin
            res.zero = 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cf2ci_merge.sv =====
// ============================================================================
// cf2ci_merge: applies sign and saturation and packs both lanes
// Joins the real and imaginary lane results into one output request.
// ============================================================================
`default_nettype none
module cf2ci_merge
(
    input  cf2ci_pkg::lane_res_t  re,
    input  cf2ci_pkg::lane_res_t  im,
    output cf2ci_pkg::out_item_t  item
);
    function automatic logic [31:0] finish(input cf2ci_pkg::lane_res_t r);
        logic [31:0] v;
        if (r.zero)
            v = '0;
        else if (r.sat)
            v = r.sign ? cf2ci_pkg::FixMin : cf2ci_pkg::FixMax;
        else
            v = r.sign ? (32'd0 - r.mag) : r.mag;
        return v;
    endfunction

    assign item.real_fixed = finish(re);
    assign item.imag_fixed = finish(im);
endmodule
`default_nettype wire

// ===== hw/rtl/complex_float_to_cint32.sv =====
// ============================================================================
// complex_float_to_cint32: complex float32 to signed 32-bit fixed point
// Two conversion lanes feed a merge stage through a stage register.
// ============================================================================
// One request per clock while not stalled: the lanes decode and shift
// into a stage register, the merge applies sign and saturation into the
// output register. Stall from downstream holds both stages; a new request
// enters whenever the first stage is empty or moving on.
`default_nettype none
module complex_float_to_cint32
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire cf2ci_pkg::in_item_t      in_data,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output cf2ci_pkg::out_item_t          out_data,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [cf2ci_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [cf2ci_pkg::CfgDataW-1:0] cfg_data
);
    cf2ci_pkg::cfg_t      cfg_reg;
    cf2ci_pkg::lane_res_t re_w, im_w, re_reg, im_reg;
    cf2ci_pkg::out_item_t mrg_w, out_reg;
    logic s1_valid_reg, out_valid_reg;
    logic adv2, adv1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fraction_bits <= '0;
            cfg_reg.safe_mode <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cf2ci_pkg::RegFractionBits:
                    cfg_reg.fraction_bits <= cfg_data[cf2ci_pkg::FracW-1:0];
                cf2ci_pkg::RegSafeMode: cfg_reg.safe_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cf2ci_lane u_lane_re (.bits(in_data.real_bits), .cfg(cfg_reg), .res(re_w));
    cf2ci_lane u_lane_im (.bits(in_data.imag_bits), .cfg(cfg_reg), .res(im_w));
    cf2ci_merge u_merge (.re(re_reg), .im(im_reg), .item(mrg_w));

    assign adv2 = !out_valid_reg || !out_stall;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            re_reg <= re_w;
            im_reg <= im_w;
        end
        if (adv2 && s1_valid_reg)
            out_reg <= mrg_w;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("output changed under stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && adv2 |=> out_valid_reg)
        else $error("stage request lost");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("stall without full pipe");
endmodule
`default_nettype wire

// ===== verif/complex_float_to_cint32_tb.sv =====
// ============================================================================
// complex_float_to_cint32_tb: conversion checker for complex float to cint32
// Drives float32 pairs under several fraction/rounding settings, predicts the
// fixed-point pair per request and compares each output in order.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module complex_float_to_cint32_tb;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    cf2ci_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    cf2ci_pkg::out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [cf2ci_pkg::CfgIdxW-1:0] cfg_index;
    logic [cf2ci_pkg::CfgDataW-1:0] cfg_data;

    complex_float_to_cint32 dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [cf2ci_pkg::FracW-1:0] frac_shadow;
    logic safe_shadow;
    cf2ci_pkg::out_item_t fixed_queue[$];
    int unsigned mismatches;
    bit idle_enable;
    bit rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [31:0] to_fixed(input logic [31:0] bits);
        logic sign;
        logic [7:0] expo;
        logic [63:0] mant;
        logic [63:0] mag;
        int e2;
        int k;
        sign = bits[31];
        expo = bits[30:23];
        mant = {41'd0, bits[22:0]};
        if (expo == 8'hFF)
            return (mant != 0) ? 32'd0 : (sign ? cf2ci_pkg::FixMin : cf2ci_pkg::FixMax);
        if (expo == 8'd0)
            expo = 8'd1;
        else
            mant[23] = 1'b1;
        if (mant == 0)
            return 32'd0;
        e2 = int'(expo) - 150 + int'(frac_shadow);
        if (e2 >= 0)
        begin
            if (e2 > 31)
                return sign ? cf2ci_pkg::FixMin : cf2ci_pkg::FixMax;
            mag = mant << e2;
        end
        else
        begin
            k = -e2;
            if (k >= 26)
                mag = 0;
            else
            begin
                mag = mant >> k;
                if (safe_shadow)
                    mag = mag + ((mant >> (k - 1)) & 64'd1);
            end
        end
        if (mag >= 64'h8000_0000)
            return sign ? cf2ci_pkg::FixMin : cf2ci_pkg::FixMax;
        return sign ? (32'd0 - mag[31:0]) : mag[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (fixed_queue.size() == 0)
                report_mismatch("unexpected result", out_data.real_fixed, 32'd0);
            else
            begin
                cf2ci_pkg::out_item_t want;
                want = fixed_queue.pop_front();
                if (out_data.real_fixed !== want.real_fixed)
                    report_mismatch("real_fixed", out_data.real_fixed, want.real_fixed);
                if (out_data.imag_fixed !== want.imag_fixed)
                    report_mismatch("imag_fixed", out_data.imag_fixed, want.imag_fixed);
            end
        end
    end

    // receiver stall: random bursts, plus a long forced hold
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
                out_stall <= 1'b1;
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_request(input logic [31:0] re, input logic [31:0] im);
        cf2ci_pkg::in_item_t req;
        int n;
        if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req.real_bits = re;
        req.imag_bits = im;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fixed_queue.push_back({to_fixed(im), to_fixed(re)});
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (fixed_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cf2ci_pkg::CfgIdxW-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == cf2ci_pkg::RegFractionBits)
            frac_shadow = val[cf2ci_pkg::FracW-1:0];
        else if (idx == cf2ci_pkg::RegSafeMode)
            safe_shadow = val[0];
    endtask

    task automatic set_mode(input int frac, input bit safe);
        write_reg(cf2ci_pkg::RegFractionBits, 32'(frac));
        write_reg(cf2ci_pkg::RegSafeMode, {31'd0, safe});
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] f;
        f = $urandom();
        case ($urandom_range(0, 5))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2, 3: f[30:23] = 8'($urandom_range(100, 160));
            default: ;
        endcase
        return f;
    endfunction

    task automatic test_special_values;
        logic [31:0] pats[14];
        pats = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h3F00_0000, 32'hBF00_0000, 32'h4F00_0000, 32'hCF00_0000,
                 32'h4EFF_FFFF, 32'h7F7F_FFFF};
        foreach (pats[i])
            send_request(pats[i], pats[13 - i]);
        send_request(32'h3FC0_0000, 32'hBFC0_0000);
        send_request(32'h3F7F_FFFF, 32'hC000_0000);
        drain();
    endtask

    task automatic test_modes;
        int fracs[4];
        fracs = '{31, 15, 1, 0};
        foreach (fracs[i])
        begin
            set_mode(fracs[i], (i % 2) == 1);
            repeat (3)
                send_request(random_float(), random_float());
            send_request(32'h3F00_0000, 32'h3F80_0000);
            drain();
        end
        // unknown index must be ignored
        write_reg(8'd7, 32'hFFFF_FFFF);
    endtask

    task automatic test_backpressure;
        rx_hold = 1'b1;
        fork
            repeat (40)
                send_request(random_float(), random_float());
            begin
                repeat (60) @(posedge clk);
                rx_hold = 1'b0;
            end
        join
        drain();
    endtask

    task automatic test_random;
        for (int phase = 0; phase < 6; phase++)
        begin
            set_mode(int'($urandom_range(0, 31)), $urandom_range(0, 1) == 1);
            if (phase == 5)
                idle_enable = 1'b0;
            repeat (200)
                send_request(random_float(), random_float());
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        frac_shadow = '0;
        safe_shadow = 1'b1;
        mismatches = 0;
        idle_enable = 1'b1;
        rx_hold = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_modes();
        test_backpressure();
        test_random();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/cf2ci_pkg.sv
hw/rtl/cf2ci_lane.sv
hw/rtl/cf2ci_merge.sv
hw/rtl/complex_float_to_cint32.sv
verif/complex_float_to_cint32_tb.sv
